// ===== hw/rtl/udv_pkg.sv =====
package udv_pkg;

	// coordinate and result field widths
	localparam int COORD_W = 32;
	localparam int OUT_W   = 32;
	// exact difference, its square and the sum of three squares
	localparam int MAG_W   = COORD_W + 1;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int LANES   = 3;

	typedef struct packed {
		logic signed [COORD_W-1:0] from_x;
		logic signed [COORD_W-1:0] from_y;
		logic signed [COORD_W-1:0] from_z;
		logic signed [COORD_W-1:0] to_x;
		logic signed [COORD_W-1:0] to_y;
		logic signed [COORD_W-1:0] to_z;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] unit_x;
		logic signed [OUT_W-1:0] unit_y;
		logic signed [OUT_W-1:0] unit_z;
		logic                    zero_length;
	} out_word_t;

	typedef logic [LANES-1:0][SUM_W-1:0] sum_vec_t;

endpackage

// ===== hw/rtl/udv_prep.sv =====
module udv_prep (
	input  logic                clk,
	input  logic                en,
	input  udv_pkg::in_word_t   in_data,
	output udv_pkg::sum_vec_t   sq,
	output logic [udv_pkg::SUM_W-1:0] len_sq,
	output logic [udv_pkg::LANES-1:0] neg,
	output logic                zero
);

	logic signed [udv_pkg::COORD_W-1:0] from_c [udv_pkg::LANES];
	logic signed [udv_pkg::COORD_W-1:0] to_c   [udv_pkg::LANES];
	logic signed [udv_pkg::MAG_W-1:0]   diff   [udv_pkg::LANES];
	logic [udv_pkg::LANES-1:0][udv_pkg::MAG_W-1:0] mag_s1;
	logic [udv_pkg::LANES-1:0]          neg_s1, neg_s2, neg_s3;
	logic [udv_pkg::LANES-1:0][udv_pkg::SQ_W-1:0] sq_s2;
	udv_pkg::sum_vec_t                  sq_s3;
	logic [udv_pkg::SUM_W-1:0]          sum_s3;

	always_comb begin
		from_c[0] = in_data.from_x;
		from_c[1] = in_data.from_y;
		from_c[2] = in_data.from_z;
		to_c[0]   = in_data.to_x;
		to_c[1]   = in_data.to_y;
		to_c[2]   = in_data.to_z;
		for (int c = 0; c < udv_pkg::LANES; c++) begin
			diff[c] = udv_pkg::MAG_W'(to_c[c]) - udv_pkg::MAG_W'(from_c[c]);
		end
	end

	// stage 1: exact difference, split into magnitude and sign
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < udv_pkg::LANES; c++) begin
				mag_s1[c] <= diff[c][udv_pkg::MAG_W-1] ? -diff[c] : diff[c];
				neg_s1[c] <= diff[c][udv_pkg::MAG_W-1];
			end
		end
	end

	// stage 2: one square per lane
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < udv_pkg::LANES; c++) begin
				sq_s2[c] <= udv_pkg::SQ_W'(mag_s1[c]) * udv_pkg::SQ_W'(mag_s1[c]);
			end
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: squared length
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < udv_pkg::LANES; c++) begin
				sq_s3[c] <= udv_pkg::SUM_W'(sq_s2[c]);
			end
			sum_s3 <= udv_pkg::SUM_W'(sq_s2[0]) + udv_pkg::SUM_W'(sq_s2[1])
				+ udv_pkg::SUM_W'(sq_s2[2]);
			neg_s3 <= neg_s2;
		end
	end

	assign sq     = sq_s3;
	assign len_sq = sum_s3;
	assign neg    = neg_s3;
	assign zero   = (sum_s3 == '0);

endmodule

// ===== hw/rtl/udv_div_cell.sv =====
module udv_div_cell #(
	parameter int FIRST = 0,
	parameter int T_W   = 63
) (
	input  logic                          clk,
	input  logic                          en,
	input  udv_pkg::sum_vec_t             rem_in,
	input  logic [udv_pkg::SUM_W-1:0]     den_in,
	input  logic [udv_pkg::LANES-1:0][T_W-1:0] quo_in,
	output udv_pkg::sum_vec_t             rem_out,
	output logic [udv_pkg::SUM_W-1:0]     den_out,
	output logic [udv_pkg::LANES-1:0][T_W-1:0] quo_out
);

	udv_pkg::sum_vec_t                    rem_q;
	logic [udv_pkg::SUM_W-1:0]            den_q;
	logic [udv_pkg::LANES-1:0][T_W-1:0]   quo_q;
	logic [udv_pkg::SUM_W-1:0]            trial [udv_pkg::LANES];
	logic [udv_pkg::LANES-1:0]            fits;

	// one restoring division step per lane, shared divisor
	always_comb begin
		for (int c = 0; c < udv_pkg::LANES; c++) begin
			trial[c] = (FIRST != 0) ? rem_in[c] : {rem_in[c][udv_pkg::SUM_W-2:0], 1'b0};
			fits[c]  = (trial[c] >= den_in);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < udv_pkg::LANES; c++) begin
				rem_q[c] <= fits[c] ? trial[c] - den_in : trial[c];
				quo_q[c] <= {quo_in[c][T_W-2:0], fits[c]};
			end
			den_q <= den_in;
		end
	end

	assign rem_out = rem_q;
	assign den_out = den_q;
	assign quo_out = quo_q;

endmodule

// ===== hw/rtl/udv_sqrt_cell.sv =====
module udv_sqrt_cell #(
	parameter int TP = 64,
	parameter int NR = 32
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [udv_pkg::LANES-1:0][TP-1:0]     rad_in,
	input  logic [udv_pkg::LANES-1:0][NR-1:0]     root_in,
	input  logic [udv_pkg::LANES-1:0][NR+1:0]     rem_in,
	output logic [udv_pkg::LANES-1:0][TP-1:0]     rad_out,
	output logic [udv_pkg::LANES-1:0][NR-1:0]     root_out,
	output logic [udv_pkg::LANES-1:0][NR+1:0]     rem_out
);

	logic [udv_pkg::LANES-1:0][TP-1:0] rad_q;
	logic [udv_pkg::LANES-1:0][NR-1:0] root_q;
	logic [udv_pkg::LANES-1:0][NR+1:0] rem_q;
	logic [NR+3:0]                     cur   [udv_pkg::LANES];
	logic [NR+3:0]                     trial [udv_pkg::LANES];
	logic [udv_pkg::LANES-1:0]         fits;

	// one root digit per lane: bring down two radicand bits, try 4r+1
	always_comb begin
		for (int c = 0; c < udv_pkg::LANES; c++) begin
			cur[c]   = {rem_in[c], rad_in[c][TP-1:TP-2]};
			trial[c] = {2'b00, root_in[c], 2'b01};
			fits[c]  = (cur[c] >= trial[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < udv_pkg::LANES; c++) begin
				rad_q[c]  <= {rad_in[c][TP-3:0], 2'b00};
				root_q[c] <= {root_in[c][NR-2:0], fits[c]};
				rem_q[c]  <= fits[c] ? (NR+2)'(cur[c] - trial[c]) : (NR+2)'(cur[c]);
			end
		end
	end

	assign rad_out  = rad_q;
	assign root_out = root_q;
	assign rem_out  = rem_q;

endmodule

// ===== hw/rtl/unit_direction_vector_3d.sv =====
// unit direction from one 3d point to another. each input word holds two
// points in signed q16.16; each output word holds the three components of
// (to - from) / |to - from| in signed fixed point with OUT_FRAC_BITS fraction
// bits, rounded to nearest with ties away from zero and exact before that one
// rounding. coincident points give zero_length = 1 and all components zero.
// the datapath is one fixed pipeline: three front stages (difference,
// squares, squared length), a row of 2*OUT_FRAC_BITS+3 long-division cells,
// a row of OUT_FRAC_BITS+2 square-root cells and an output register.
// one word is accepted every cycle; the whole pipeline holds only while a
// finished word waits at the output and out_ready is low.
module unit_direction_vector_3d #(
	parameter int OUT_FRAC_BITS = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  udv_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output udv_pkg::out_word_t  out_data
);

	// quotient bits of d^2 * 2^(2F+2) / S, radicand padded to even width,
	// root digits
	localparam int T_W = 2 * OUT_FRAC_BITS + 3;
	localparam int TP  = T_W + 1;
	localparam int NR  = TP / 2;
	localparam int ND  = T_W;
	localparam int LAT = 3 + ND + NR + 1;
	localparam int SB  = ND + NR;

	logic adv;

	// valid of each stage
	logic [LAT-1:0] vld_q;

	// front end
	udv_pkg::sum_vec_t               pre_sq;
	logic [udv_pkg::SUM_W-1:0]       pre_len;
	logic [udv_pkg::LANES-1:0]       pre_neg;
	logic                            pre_zero;

	// sideband that rides along the division and root rows
	logic [udv_pkg::LANES-1:0]       neg_q  [SB];
	logic                            zero_q [SB];

	// division row
	udv_pkg::sum_vec_t               d_rem  [ND+1];
	logic [udv_pkg::SUM_W-1:0]       d_den  [ND+1];
	logic [udv_pkg::LANES-1:0][T_W-1:0] d_quo [ND+1];

	// root row
	logic [udv_pkg::LANES-1:0][TP-1:0]  s_rad  [NR+1];
	logic [udv_pkg::LANES-1:0][NR-1:0]  s_root [NR+1];
	logic [udv_pkg::LANES-1:0][NR+1:0]  s_rem  [NR+1];

	// rounding and sign
	logic [NR:0]                     q_mag [udv_pkg::LANES];
	logic signed [NR:0]              q_sgn [udv_pkg::LANES];
	logic signed [udv_pkg::OUT_W-1:0] unit_c [udv_pkg::LANES];
	udv_pkg::out_word_t              out_q;

	// the pipe moves whenever the output register is free or being emptied
	assign adv      = !vld_q[LAT-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	udv_prep u_prep (
		.clk     (clk),
		.en      (adv),
		.in_data (in_data),
		.sq      (pre_sq),
		.len_sq  (pre_len),
		.neg     (pre_neg),
		.zero    (pre_zero)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_q[0]  <= pre_neg;
			zero_q[0] <= pre_zero;
			for (int i = 1; i < SB; i++) begin
				neg_q[i]  <= neg_q[i-1];
				zero_q[i] <= zero_q[i-1];
			end
		end
	end

	// division cells: first one compares the square itself, the rest shift
	assign d_rem[0] = pre_sq;
	assign d_den[0] = pre_len;
	assign d_quo[0] = '0;

	for (genvar k = 0; k < ND; k++) begin : g_div
		udv_div_cell #(
			.FIRST ((k == 0) ? 1 : 0),
			.T_W   (T_W)
		) u_cell (
			.clk     (clk),
			.en      (adv),
			.rem_in  (d_rem[k]),
			.den_in  (d_den[k]),
			.quo_in  (d_quo[k]),
			.rem_out (d_rem[k+1]),
			.den_out (d_den[k+1]),
			.quo_out (d_quo[k+1])
		);
	end

	// root cells: the quotient enters right aligned, zero padded at the top to an even-width radicand
	for (genvar c = 0; c < udv_pkg::LANES; c++) begin : g_rad
		assign s_rad[0][c] = {1'b0, d_quo[ND][c]};
	end
	assign s_root[0] = '0;
	assign s_rem[0]  = '0;

	for (genvar k = 0; k < NR; k++) begin : g_sqrt
		udv_sqrt_cell #(
			.TP (TP),
			.NR (NR)
		) u_cell (
			.clk      (clk),
			.en       (adv),
			.rad_in   (s_rad[k]),
			.root_in  (s_root[k]),
			.rem_in   (s_rem[k]),
			.rad_out  (s_rad[k+1]),
			.root_out (s_root[k+1]),
			.rem_out  (s_rem[k+1])
		);
	end

	// largest q with (2q-1)^2 <= t is (isqrt(t)+1)/2, then the sign
	always_comb begin
		for (int c = 0; c < udv_pkg::LANES; c++) begin
			q_mag[c]  = ((NR+1)'(s_root[NR][c]) + (NR+1)'(1)) >> 1;
			q_sgn[c]  = neg_q[SB-1][c] ? -$signed(q_mag[c]) : $signed(q_mag[c]);
			unit_c[c] = zero_q[SB-1] ? '0 : udv_pkg::OUT_W'(q_sgn[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.unit_x      <= unit_c[0];
			out_q.unit_y      <= unit_c[1];
			out_q.unit_z      <= unit_c[2];
			out_q.zero_length <= zero_q[SB-1];
		end
	end

	assign out_valid = vld_q[LAT-1];
	assign out_data  = out_q;

endmodule
